[hw/rtl/assert_macros.svh]
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VRP_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define VRP_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/vrp_pkg.sv]
`default_nettype none
package vrp_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;
  localparam int ANGLE_BITS = 16;
  localparam int SCALE_BITS = 16;
  localparam int SIZE_BITS  = 13;
  localparam int HALF_BITS  = 12;
  localparam int Q14_BITS   = 16;
  localparam int Q14_FRAC   = 14;
  localparam int COEF_BITS  = 18;
  localparam int CORD_XW    = 20;
  localparam int CORD_ZW    = 33;
  localparam int ATAN_COUNT = 24;

  localparam logic signed [CORD_XW-1:0] CORD_GAIN = 20'sd39797;

  localparam logic [2:0] REG_ANGLE_X       = 3'd0;
  localparam logic [2:0] REG_ANGLE_Y       = 3'd1;
  localparam logic [2:0] REG_ANGLE_Z       = 3'd2;
  localparam logic [2:0] REG_PROJ_SCALE    = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;

  // rotated coordinate, depth and numerator widths for a given coordinate width
  function automatic int rw_of(input int v);
    return COEF_BITS + v + 2 - Q14_FRAC;
  endfunction

  function automatic int dw_of(input int v);
    return rw_of(v) + 4;
  endfunction

  function automatic int nw_of(input int v);
    int a;
    int b;
    a = HALF_BITS + 1 + dw_of(v);
    b = SCALE_BITS + 1 + rw_of(v);
    return ((a > b) ? a : b) + 1;
  endfunction

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [CORD_ZW-1:0] atan_turn(input logic [4:0] i);
    logic signed [CORD_ZW-1:0] r;
    case (i)
      5'd0:  r = 33'sd536870912;
      5'd1:  r = 33'sd316933406;
      5'd2:  r = 33'sd167458907;
      5'd3:  r = 33'sd85004756;
      5'd4:  r = 33'sd42667331;
      5'd5:  r = 33'sd21354465;
      5'd6:  r = 33'sd10679838;
      5'd7:  r = 33'sd5340245;
      5'd8:  r = 33'sd2670163;
      5'd9:  r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q1.14 product rounded back to q1.14
  function automatic logic signed [Q14_BITS-1:0] mulq(input logic signed [Q14_BITS-1:0] a,
                                                      input logic signed [Q14_BITS-1:0] b);
    logic signed [2*Q14_BITS-1:0] p;
    p = a * b;
    p = p + (2*Q14_BITS)'(1 << (Q14_FRAC - 1));
    return Q14_BITS'(p >>> Q14_FRAC);
  endfunction

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle_x;
    logic [ANGLE_BITS-1:0] angle_y;
    logic [ANGLE_BITS-1:0] angle_z;
    logic [SCALE_BITS-1:0] proj_scale;
    logic [SIZE_BITS-1:0]  screen_width;
    logic [SIZE_BITS-1:0]  screen_height;
    logic                  angle_wr;
  } cfg_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] m00;
    logic signed [COEF_BITS-1:0] m01;
    logic signed [COEF_BITS-1:0] m02;
    logic signed [COEF_BITS-1:0] m10;
    logic signed [COEF_BITS-1:0] m11;
    logic signed [COEF_BITS-1:0] m12;
    logic signed [COEF_BITS-1:0] m20;
    logic signed [COEF_BITS-1:0] m21;
    logic signed [COEF_BITS-1:0] m22;
  } coef_t;

endpackage
`default_nettype wire

[hw/rtl/vrp_regs.sv]
`default_nettype none
module vrp_regs
  import vrp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  logic [ANGLE_BITS-1:0] angle_x;
  logic [ANGLE_BITS-1:0] angle_y;
  logic [ANGLE_BITS-1:0] angle_z;
  logic [SCALE_BITS-1:0] proj_scale;
  logic [SIZE_BITS-1:0]  screen_width;
  logic [SIZE_BITS-1:0]  screen_height;
  logic [2:0]            idx;
  logic                  wr;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x       <= '0;
      angle_y       <= '0;
      angle_z       <= '0;
      proj_scale    <= SCALE_BITS'(3200);
      screen_width  <= SIZE_BITS'(1920);
      screen_height <= SIZE_BITS'(1080);
    end else if (wr) begin
      unique case (idx)
        REG_ANGLE_X:       angle_x       <= pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_Y:       angle_y       <= pwdata[ANGLE_BITS-1:0];
        REG_ANGLE_Z:       angle_z       <= pwdata[ANGLE_BITS-1:0];
        REG_PROJ_SCALE:    proj_scale    <= pwdata[SCALE_BITS-1:0];
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[SIZE_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ANGLE_X:       prdata = DATA_BITS'(angle_x);
      REG_ANGLE_Y:       prdata = DATA_BITS'(angle_y);
      REG_ANGLE_Z:       prdata = DATA_BITS'(angle_z);
      REG_PROJ_SCALE:    prdata = DATA_BITS'(proj_scale);
      REG_SCREEN_WIDTH:  prdata = DATA_BITS'(screen_width);
      REG_SCREEN_HEIGHT: prdata = DATA_BITS'(screen_height);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    cfg.angle_x       = angle_x;
    cfg.angle_y       = angle_y;
    cfg.angle_z       = angle_z;
    cfg.proj_scale    = proj_scale;
    cfg.screen_width  = screen_width;
    cfg.screen_height = screen_height;
    cfg.angle_wr      = wr && (idx == REG_ANGLE_X || idx == REG_ANGLE_Y || idx == REG_ANGLE_Z);
  end

endmodule
`default_nettype wire

[hw/rtl/vrp_coef.sv]
`default_nettype none
module vrp_coef
  import vrp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  output coef_t     coef,
  output logic      busy
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_ROT  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_MUL1 = 3'd4;
  localparam logic [2:0] ST_MUL2 = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;

  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;

  localparam logic signed [CORD_XW-1:0] LIM = CORD_XW'(16384);

  function automatic logic signed [Q14_BITS-1:0] round_clamp(
      input logic signed [CORD_XW-1:0] v);
    logic signed [CORD_XW-1:0] r;
    r = (v + CORD_XW'(2)) >>> 2;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return Q14_BITS'(r);
  endfunction

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;

  logic [ANGLE_BITS-1:0]       phase [0:2];
  logic [1:0]                  quad  [0:2];
  logic signed [CORD_XW-1:0]   cx_r  [0:2];
  logic signed [CORD_XW-1:0]   cy_r  [0:2];
  logic signed [CORD_ZW-1:0]   cz_r  [0:2];
  logic signed [Q14_BITS-1:0]  sn    [0:2];
  logic signed [Q14_BITS-1:0]  cs    [0:2];
  logic signed [CORD_ZW-1:0]   atan;

  // products of the coefficient matrix
  logic signed [Q14_BITS-1:0] t_cycz, t_cysz, t_sysx, t_sysz, t_cysx, t_cxsz;
  logic signed [Q14_BITS-1:0] t_cxcz, t_sxsy, t_cxsy, t_cxcy, t_czsx;
  logic signed [Q14_BITS-1:0] t_sxsysz, t_cxsysz;

  assign phase[0] = cfg.angle_x;
  assign phase[1] = cfg.angle_y;
  assign phase[2] = cfg.angle_z;
  assign atan     = atan_turn(5'(cnt));
  assign busy     = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
    end else if (cfg.angle_wr) begin
      state <= ST_LOAD;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: state <= ST_IDLE;
        ST_LOAD: begin
          state <= ST_ROT;
          cnt   <= '0;
        end
        ST_ROT: begin
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) state <= ST_FIN;
          cnt <= cnt + 1'b1;
        end
        ST_FIN:  state <= ST_MUL1;
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_SUM;
        ST_SUM:  state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (state == ST_LOAD) begin
        cx_r[l] <= CORD_GAIN;
        cy_r[l] <= '0;
        cz_r[l] <= $signed({3'b000, phase[l][13:0], 16'h0000});
        quad[l] <= phase[l][15:14];
      end else if (state == ST_ROT) begin
        if (!cz_r[l][CORD_ZW-1]) begin
          cx_r[l] <= cx_r[l] - (cy_r[l] >>> cnt);
          cy_r[l] <= cy_r[l] + (cx_r[l] >>> cnt);
          cz_r[l] <= cz_r[l] - atan;
        end else begin
          cx_r[l] <= cx_r[l] + (cy_r[l] >>> cnt);
          cy_r[l] <= cy_r[l] - (cx_r[l] >>> cnt);
          cz_r[l] <= cz_r[l] + atan;
        end
      end else if (state == ST_FIN) begin
        case (quad[l])
          QUAD_0: begin
            cs[l] <= round_clamp(cx_r[l]);
            sn[l] <= round_clamp(cy_r[l]);
          end
          QUAD_90: begin
            cs[l] <= -round_clamp(cy_r[l]);
            sn[l] <= round_clamp(cx_r[l]);
          end
          QUAD_180: begin
            cs[l] <= -round_clamp(cx_r[l]);
            sn[l] <= -round_clamp(cy_r[l]);
          end
          default: begin
            cs[l] <= round_clamp(cy_r[l]);
            sn[l] <= -round_clamp(cx_r[l]);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL1) begin
      t_cycz <= mulq(cs[1], cs[2]);
      t_cysz <= mulq(cs[1], sn[2]);
      t_sysx <= mulq(sn[1], sn[0]);
      t_sysz <= mulq(sn[1], sn[2]);
      t_cysx <= mulq(cs[1], sn[0]);
      t_cxsz <= mulq(cs[0], sn[2]);
      t_cxcz <= mulq(cs[0], cs[2]);
      t_sxsy <= mulq(sn[0], sn[1]);
      t_cxsy <= mulq(cs[0], sn[1]);
      t_cxcy <= mulq(cs[0], cs[1]);
      t_czsx <= mulq(cs[2], sn[0]);
    end
    if (state == ST_MUL2) begin
      t_sxsysz <= mulq(t_sxsy, sn[2]);
      t_cxsysz <= mulq(t_cxsy, sn[2]);
    end
    if (state == ST_SUM) begin
      coef.m00 <= COEF_BITS'(t_cycz);
      coef.m01 <= COEF_BITS'(t_cysz) + COEF_BITS'(t_sysx);
      coef.m02 <= COEF_BITS'(t_sysz) - COEF_BITS'(t_cysx);
      coef.m10 <= COEF_BITS'(t_cxsz);
      coef.m11 <= COEF_BITS'(t_cxcz) - COEF_BITS'(t_sxsysz);
      coef.m12 <= COEF_BITS'(t_cxsysz) + COEF_BITS'(t_czsx);
      coef.m20 <= COEF_BITS'(t_sxsy);
      coef.m21 <= COEF_BITS'(t_cxsy);
      coef.m22 <= COEF_BITS'(t_cxcy);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/vrp_xform.sv]
`default_nettype none
module vrp_xform
  import vrp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] vx,
  input  wire logic signed [COORD_BITS-1:0] vy,
  input  wire logic signed [COORD_BITS-1:0] vz,
  input  coef_t                             coef,
  input  cfg_t                              cfg,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [nw_of(COORD_BITS)-1:0] numx,
  output logic signed [nw_of(COORD_BITS)-1:0] numy,
  output logic signed [dw_of(COORD_BITS)-1:0] den,
  output logic                              dz
);

  localparam int PW = COEF_BITS + COORD_BITS;
  localparam int SW = PW + 2;
  localparam int RW = rw_of(COORD_BITS);
  localparam int DW = dw_of(COORD_BITS);
  localparam int NW = nw_of(COORD_BITS);
  localparam int HP = HALF_BITS + 1 + DW;
  localparam int SP = SCALE_BITS + 1 + RW;

  logic vld1, vld2;
  logic en1, en2, en3;

  logic signed [PW-1:0] prod [0:8];
  logic signed [PW-1:0] p1   [0:8];
  logic signed [SW-1:0] sum  [0:2];
  logic signed [RW-1:0] r2   [0:2];

  logic signed [DW-1:0]       den_c;
  logic signed [HALF_BITS:0]  hw_s, hh_s;
  logic signed [SCALE_BITS:0] sc_s;
  logic signed [HP-1:0]       hwd, hhd;
  logic signed [SP-1:0]       scx, scy;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !vld2 || en3;
  assign en1      = !vld1 || en2;
  assign in_ready = en1;

  always_comb begin
    prod[0] = coef.m00 * vx;
    prod[1] = coef.m01 * vy;
    prod[2] = coef.m02 * vz;
    prod[3] = coef.m10 * vx;
    prod[4] = coef.m11 * vy;
    prod[5] = coef.m12 * vz;
    prod[6] = coef.m20 * vx;
    prod[7] = coef.m21 * vy;
    prod[8] = coef.m22 * vz;
  end

  // row sums with q.14 rounding
  for (genvar j = 0; j < 3; j++) begin : g_row
    assign sum[j] = SW'(p1[3*j]) + SW'(p1[3*j+1]) + SW'(p1[3*j+2])
                  + SW'(1 << (Q14_FRAC - 1));
  end

  assign den_c = $signed({r2[2], 4'b0000});
  assign hw_s  = $signed({1'b0, cfg.screen_width[SIZE_BITS-1:1]});
  assign hh_s  = $signed({1'b0, cfg.screen_height[SIZE_BITS-1:1]});
  assign sc_s  = $signed({1'b0, cfg.proj_scale});
  assign hwd   = hw_s * den_c;
  assign hhd   = hh_s * den_c;
  assign scx   = sc_s * r2[0];
  assign scy   = sc_s * r2[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) vld1 <= in_valid;
      if (en2) vld2 <= vld1;
      if (en3) out_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 9; i++) p1[i] <= prod[i];
    end
    if (en2) begin
      for (int j = 0; j < 3; j++) r2[j] <= RW'(sum[j] >>> Q14_FRAC);
    end
    if (en3) begin
      numx <= NW'(hwd) + NW'(scx);
      numy <= NW'(hhd) - NW'(scy);
      den  <= den_c;
      dz   <= (r2[2] == '0);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/vrp_div.sv]
`default_nettype none
module vrp_div
  import vrp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [nw_of(COORD_BITS)-1:0] numx,
  input  wire logic signed [nw_of(COORD_BITS)-1:0] numy,
  input  wire logic signed [dw_of(COORD_BITS)-1:0] den,
  input  wire logic                                dz,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [COORD_BITS-1:0]             qx,
  output logic signed [COORD_BITS-1:0]             qy,
  output logic                                     qdz
);

  localparam int V  = COORD_BITS;
  localparam int DW = dw_of(V);
  localparam int NW = nw_of(V);
  localparam int WW = (NW > DW + V) ? NW : DW + V;

  localparam logic [V-1:0] HI = {1'b0, {(V-1){1'b1}}};
  localparam logic [V-1:0] LO = {1'b1, {(V-1){1'b0}}};

  logic           vld   [0:V];
  logic           en    [0:V+1];
  logic [WW-1:0]  rem_x [0:V];
  logic [WW-1:0]  rem_y [0:V];
  logic [V-1:0]   q_x   [0:V];
  logic [V-1:0]   q_y   [0:V];
  logic [DW-1:0]  ad    [0:V];
  logic           neg_x [0:V];
  logic           neg_y [0:V];
  logic           ov_x  [0:V];
  logic           ov_y  [0:V];
  logic           dzp   [0:V];

  logic [NW-1:0] ax_c, ay_c;
  logic [DW-1:0] ad_c;
  logic [WW-1:0] lim_c;

  function automatic logic [V-1:0] sat(input logic [V-1:0] q, input logic neg,
                                       input logic ov);
    logic [V-1:0] r;
    if (neg) begin
      r = (ov || (q[V-1] && (q[V-2:0] != '0))) ? LO : (~q + 1'b1);
    end else begin
      r = (ov || q[V-1]) ? HI : q;
    end
    return r;
  endfunction

  assign en[V+1]  = !out_valid || !out_stall;
  assign in_ready = en[0];

  for (genvar k = 0; k <= V; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  // magnitudes and overflow test
  assign ax_c  = numx[NW-1] ? NW'(-numx) : NW'(numx);
  assign ay_c  = numy[NW-1] ? NW'(-numy) : NW'(numy);
  assign ad_c  = den[DW-1] ? DW'(-den) : DW'(den);
  assign lim_c = WW'(ad_c) << V;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_x[0] <= WW'(ax_c);
      rem_y[0] <= WW'(ay_c);
      q_x[0]   <= '0;
      q_y[0]   <= '0;
      ad[0]    <= ad_c;
      neg_x[0] <= numx[NW-1] ^ den[DW-1];
      neg_y[0] <= numy[NW-1] ^ den[DW-1];
      ov_x[0]  <= WW'(ax_c) >= lim_c;
      ov_y[0]  <= WW'(ay_c) >= lim_c;
      dzp[0]   <= dz;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= V; k++) begin : g_stage
    localparam int B = V - k;
    logic [WW-1:0] dsh;
    logic          ge_x, ge_y;

    assign dsh  = WW'(ad[k-1]) << B;
    assign ge_x = rem_x[k-1] >= dsh;
    assign ge_y = rem_y[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_x[k] <= ge_x ? rem_x[k-1] - dsh : rem_x[k-1];
        rem_y[k] <= ge_y ? rem_y[k-1] - dsh : rem_y[k-1];
        q_x[k]   <= q_x[k-1] | (V'(ge_x) << B);
        q_y[k]   <= q_y[k-1] | (V'(ge_y) << B);
        ad[k]    <= ad[k-1];
        neg_x[k] <= neg_x[k-1];
        neg_y[k] <= neg_y[k-1];
        ov_x[k]  <= ov_x[k-1];
        ov_y[k]  <= ov_y[k-1];
        dzp[k]   <= dzp[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[V+1]) begin
      out_valid <= vld[V];
    end
  end

  always_ff @(posedge clk) begin
    if (en[V+1]) begin
      qdz <= dzp[V];
      if (dzp[V]) begin
        qx <= '0;
        qy <= '0;
      end else begin
        qx <= $signed(sat(q_x[V], neg_x[V], ov_x[V]));
        qy <= $signed(sat(q_y[V], neg_y[V], ov_y[V]));
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/vertex_rotate_project.sv]
// a vertex passes the transform, then the divider's input, bit and output registers
// one vertex per cycle when not stalled, set by the fully pipelined transform and divider
// after reset and after each angle write the input stalls
// while the shared cordic sequencer rebuilds the matrix
// reset: synchronous, active high; registers return to angle 0, scale 200.0, 1920x1080
`default_nettype none
module vertex_rotate_project
  import vrp_pkg::*;
#(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ADDR_BITS-1:0]         paddr,
  input  wire logic [DATA_BITS-1:0]         pwdata,
  output logic      [DATA_BITS-1:0]         prdata,
  output logic                              pready,
  // vertex beats in
  input  wire logic                         vertex_valid,
  output logic                              vertex_stall,
  input  wire logic signed [COORD_BITS-1:0] vertex_x,
  input  wire logic signed [COORD_BITS-1:0] vertex_y,
  input  wire logic signed [COORD_BITS-1:0] vertex_z,
  // screen beats out
  output logic                              screen_valid,
  input  wire logic                         screen_stall,
  output logic signed [COORD_BITS-1:0]      screen_x,
  output logic signed [COORD_BITS-1:0]      screen_y,
  output logic                              depth_zero
);

  localparam int DW = dw_of(COORD_BITS);
  localparam int NW = nw_of(COORD_BITS);

  cfg_t  cfg;
  coef_t coef;
  logic  busy;

  // handshake between the transform and the divider
  logic                 xf_ready;
  logic                 xf_valid;
  logic                 dv_ready;
  logic signed [NW-1:0] numx, numy;
  logic signed [DW-1:0] den;
  logic                 dz;

  // register file; angle writes retrigger the coefficient build at once
  vrp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequential cordic for the three angles, then the matrix products
  vrp_coef #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_coef (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .coef (coef),
    .busy (busy)
  );

  // no vertex enters while the matrix is being rebuilt
  assign vertex_stall = busy || !xf_ready;

  // matrix multiply, rounding and projection numerators: three stages
  vrp_xform #(
    .COORD_BITS (COORD_BITS)
  ) u_xform (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex_valid && !busy),
    .in_ready  (xf_ready),
    .vx        (vertex_x),
    .vy        (vertex_y),
    .vz        (vertex_z),
    .coef      (coef),
    .cfg       (cfg),
    .out_valid (xf_valid),
    .out_stall (!dv_ready),
    .numx      (numx),
    .numy      (numy),
    .den       (den),
    .dz        (dz)
  );

  // restoring divider, one quotient bit per stage, then saturation into the
  // output register; each stage holds on its own so bubbles close up under stall
  vrp_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (xf_valid),
    .in_ready  (dv_ready),
    .numx      (numx),
    .numy      (numy),
    .den       (den),
    .dz        (dz),
    .out_valid (screen_valid),
    .out_stall (screen_stall),
    .qx        (screen_x),
    .qy        (screen_y),
    .qdz       (depth_zero)
  );

endmodule
`default_nettype wire

[hw/rtl/vrp_check.sv]
`default_nettype none
`include "assert_macros.svh"
module vrp_check
  import vrp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [ADDR_BITS-1:0]         paddr,
  input wire logic                         vertex_stall,
  input wire logic                         screen_valid,
  input wire logic                         screen_stall,
  input wire logic signed [COORD_BITS-1:0] screen_x,
  input wire logic signed [COORD_BITS-1:0] screen_y,
  input wire logic                         depth_zero
);

  logic angle_wr;

  assign angle_wr = psel && penable && pwrite &&
                    (paddr[4:2] == REG_ANGLE_X || paddr[4:2] == REG_ANGLE_Y ||
                     paddr[4:2] == REG_ANGLE_Z);

  // zero depth gives the origin
  `VRP_ASSERT_IMP(a_dz_origin, clk, rst, screen_valid && depth_zero, screen_x == '0 && screen_y == '0)
  // matrix rebuild blocks input after reset
  `VRP_ASSERT_NXT(a_rst_stall, clk, 1'b0, rst, vertex_stall)
  // and after an angle write
  `VRP_ASSERT_NXT(a_angle_stall, clk, rst, angle_wr, vertex_stall)
  // a stalled output beat holds
  `VRP_ASSERT_NXT(a_out_hold, clk, rst, screen_valid && screen_stall, screen_valid && $stable(screen_x) && $stable(screen_y) && $stable(depth_zero))

endmodule

bind vertex_rotate_project vrp_check #(.COORD_BITS(COORD_BITS)) u_check (
  .clk          (clk),
  .rst          (rst),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .vertex_stall (vertex_stall),
  .screen_valid (screen_valid),
  .screen_stall (screen_stall),
  .screen_x     (screen_x),
  .screen_y     (screen_y),
  .depth_zero   (depth_zero)
);
`default_nettype wire
